// ----- sv/jst_pkg.sv -----
// Shared types and constants for the job slot table with age order.
// Field widths and positions on the stream buses, action codes and the
// controller-to-datapath command and status structs. No dependencies.
package jst_pkg;

  // default sizing of the top level
  localparam int JOBS_DEF  = 16;
  localparam int PROCS_DEF = 1024;

  // item field widths
  localparam int ACT_W   = 2;
  localparam int PID_W   = 10;
  localparam int GRP_W   = 22;
  localparam int CNT_W   = 8;
  localparam int JST_W   = 3;
  localparam int SLOT_W  = 4;
  localparam int STAMP_W = 32;

  // input tdata layout, lowest bit first
  localparam int PID_LO  = 0;
  localparam int GRP_LO  = PID_LO + PID_W;
  localparam int CNT_LO  = GRP_LO + GRP_W;
  localparam int JST_LO  = CNT_LO + CNT_W;
  localparam int RSL_LO  = JST_LO + JST_W;
  localparam int IN_TDATA_W = ((RSL_LO + SLOT_W + 7) / 8) * 8;
  localparam int IN_TUSER_W = ACT_W;

  // output tdata layout, lowest bit first
  localparam int OIDX_LO  = 0;
  localparam int OOK_LO   = OIDX_LO + SLOT_W;
  localparam int OREM_LO  = OOK_LO + 1;
  localparam int OST_LO   = OREM_LO + CNT_W;
  localparam int OCUR_LO  = OST_LO + JST_W;
  localparam int OPREV_LO = OCUR_LO + SLOT_W;
  localparam int OUT_TDATA_W = ((OPREV_LO + SLOT_W + 7) / 8) * 8;

  typedef enum logic [ACT_W-1:0] {
    ACT_BIND = 2'd0,
    ACT_ADD  = 2'd1,
    ACT_DONE = 2'd2,
    ACT_READ = 2'd3
  } action_t;

  typedef struct packed {
    logic clear_step;  // write zero to the next map entry
    logic latch;       // capture the item and start the map read
    logic exec;        // apply the item to the table
    logic load_out;    // pack the result into the output register
  } ctrl_cmd_t;

  typedef struct packed {
    logic clear_last;  // clearing pass is on its last map entry
  } dp_stat_t;

endpackage

// ----- sv/jst_ram.sv -----
// Generic simple dual-port RAM: one write port, one read port with
// registered read data. Standalone, no package dependencies.
module jst_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- sv/jst_ctrl.sv -----
// Controller for the job slot table: clearing pass, item sequencing and
// the output register valid. Depends on jst_pkg.
module jst_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  jst_pkg::dp_stat_t  stat,
  input  logic               in_tvalid,
  output logic               in_tready,
  output logic               out_tvalid,
  input  logic               out_tready,
  output jst_pkg::ctrl_cmd_t cmd
);
  import jst_pkg::*;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC,
    ST_FINISH
  } state_t;

  state_t state_r, state_nxt;
  logic   out_tvalid_r, out_tvalid_nxt;
  logic   out_free;
  logic   accept;

  // output register may be loaded when empty or being drained this cycle
  assign out_free  = !out_tvalid_r || out_tready;
  assign in_tready = (state_r == ST_IDLE) || ((state_r == ST_FINISH) && out_free);
  assign accept    = in_tvalid && in_tready;

  assign cmd.clear_step = (state_r == ST_CLEAR);
  assign cmd.latch      = accept;
  assign cmd.exec       = (state_r == ST_EXEC);
  assign cmd.load_out   = (state_r == ST_FINISH) && out_free;

  always_comb begin
    state_nxt      = state_r;
    out_tvalid_nxt = out_tvalid_r;
    if (out_tready) begin
      out_tvalid_nxt = 1'b0;
    end
    case (state_r)
      ST_CLEAR: begin
        if (stat.clear_last) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        state_nxt = ST_FINISH;
      end
      ST_FINISH: begin
        if (out_free) begin
          out_tvalid_nxt = 1'b1;
          state_nxt      = accept ? ST_EXEC : ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_CLEAR;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  assign out_tvalid = out_tvalid_r;

  a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (state_r == ST_EXEC))
    else $error("accepted transfer not followed by execute");

  a_exec_finish: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EXEC) |=> (state_r == ST_FINISH))
    else $error("execute not followed by finish");

  a_valid_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid_r) |-> ($past(state_r) == ST_FINISH))
    else $error("result appeared outside the finish step");

endmodule

// ----- sv/jst_dp.sv -----
// Datapath for the job slot table: item registers, process-to-group map RAM,
// slot registers, pairwise age matrix and result packing.
// Depends on jst_pkg and jst_ram.
module jst_dp #(
  parameter int JOBS  = jst_pkg::JOBS_DEF,
  parameter int PROCS = jst_pkg::PROCS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  jst_pkg::ctrl_cmd_t               cmd,
  output jst_pkg::dp_stat_t                stat,
  input  logic [jst_pkg::IN_TDATA_W-1:0]   in_tdata,
  input  logic [jst_pkg::IN_TUSER_W-1:0]   in_tuser,
  output logic [jst_pkg::OUT_TDATA_W-1:0]  out_tdata
);
  import jst_pkg::*;

  localparam int AW = $clog2(PROCS);
  localparam int SW = $clog2(JOBS);
  localparam logic [31:0]   PROCS_U  = 32'(PROCS);
  localparam logic [31:0]   JOBS_U   = 32'(JOBS);
  localparam logic [AW-1:0] CLR_LAST = AW'(PROCS - 1);

  function automatic logic [SW-1:0] enc(input logic [JOBS-1:0] oh);
    logic [SW-1:0] r;
    r = '0;
    for (int i = 0; i < JOBS; i++) begin
      if (oh[i]) begin
        r = r | SW'(i);
      end
    end
    return r;
  endfunction

  // item registers
  action_t           act_r;
  logic [PID_W-1:0]  pid_r;
  logic [GRP_W-1:0]  grp_r;
  logic [CNT_W-1:0]  cnt_r;
  logic [JST_W-1:0]  jst_r;
  logic [SLOT_W-1:0] rslot_r;

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      act_r   <= action_t'(in_tuser[ACT_W-1:0]);
      pid_r   <= in_tdata[PID_LO +: PID_W];
      grp_r   <= in_tdata[GRP_LO +: GRP_W];
      cnt_r   <= in_tdata[CNT_LO +: CNT_W];
      jst_r   <= in_tdata[JST_LO +: JST_W];
      rslot_r <= in_tdata[RSL_LO +: SLOT_W];
    end
  end

  // process-to-group map and its clearing pass
  logic [AW-1:0]    clr_cnt_r;
  logic             pid_ok;
  logic             map_we;
  logic [AW-1:0]    map_waddr;
  logic [GRP_W-1:0] map_wdata;
  logic [AW-1:0]    map_raddr;
  logic [GRP_W-1:0] map_rdata;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r <= '0;
    end else if (cmd.clear_step) begin
      clr_cnt_r <= clr_cnt_r + AW'(1);
    end
  end

  assign stat.clear_last = (clr_cnt_r == CLR_LAST);
  assign pid_ok    = (32'(pid_r) < PROCS_U);
  assign map_we    = cmd.clear_step || (cmd.exec && (act_r == ACT_BIND) && pid_ok);
  assign map_waddr = cmd.clear_step ? clr_cnt_r : AW'(pid_r);
  assign map_wdata = cmd.clear_step ? '0 : grp_r;
  assign map_raddr = AW'(in_tdata[PID_LO +: PID_W]);

  jst_ram #(
    .WIDTH(GRP_W),
    .DEPTH(PROCS)
  ) u_map (
    .clk   (clk),
    .we    (map_we),
    .waddr (map_waddr),
    .wdata (map_wdata),
    .re    (cmd.latch),
    .raddr (map_raddr),
    .rdata (map_rdata)
  );

  // slot table
  logic [GRP_W-1:0]   sgrp_r   [JOBS];
  logic [CNT_W-1:0]   srem_r   [JOBS];
  logic [JST_W-1:0]   ssts_r   [JOBS];
  logic [STAMP_W-1:0] sstamp_r [JOBS];
  logic [STAMP_W-1:0] stamp_cnt_r;
  logic [STAMP_W-1:0] stamp_nxt;
  logic [JOBS-1:0]    newer_r   [JOBS];
  logic [JOBS-1:0]    newer_nxt [JOBS];

  logic [JOBS-1:0] active, add_hit, done_hit, rem_one, ge, eq;
  logic [JOBS-1:0] is_cur, is_prev;
  logic            add_found, done_found;
  logic            add_en, add_any, done_en, done_last;

  assign stamp_nxt = stamp_cnt_r + STAMP_W'(1);

  always_comb begin
    active  = '0;
    rem_one = '0;
    for (int i = 1; i < JOBS; i++) begin
      active[i]  = (srem_r[i] != '0);
      rem_one[i] = (srem_r[i] == CNT_W'(1));
    end
    for (int j = 0; j < JOBS; j++) begin
      ge[j] = (stamp_nxt > sstamp_r[j]);
      eq[j] = (stamp_nxt == sstamp_r[j]);
    end
  end

  // lowest free slot and lowest active slot of the looked-up group, slot 0 excluded
  always_comb begin
    add_hit    = '0;
    done_hit   = '0;
    add_found  = 1'b0;
    done_found = 1'b0;
    for (int i = 1; i < JOBS; i++) begin
      if (!add_found && !active[i]) begin
        add_hit[i] = 1'b1;
        add_found  = 1'b1;
      end
      if (!done_found && active[i] && (sgrp_r[i] == map_rdata)) begin
        done_hit[i] = 1'b1;
        done_found  = 1'b1;
      end
    end
  end

  assign add_en    = cmd.exec && (act_r == ACT_ADD) && (cnt_r != '0);
  assign add_any   = |add_hit;
  assign done_en   = cmd.exec && (act_r == ACT_DONE) && pid_ok && (map_rdata != '0);
  assign done_last = |(done_hit & rem_one);

  // age matrix: newer_r[i][j] set when slot i outranks slot j
  always_comb begin
    for (int i = 0; i < JOBS; i++) begin
      for (int j = 0; j < JOBS; j++) begin
        newer_nxt[i][j] = newer_r[i][j];
        if (add_en && (i != j)) begin
          if (add_hit[i]) begin
            newer_nxt[i][j] = ge[j] | (eq[j] & (i < j));
          end else if (add_hit[j]) begin
            newer_nxt[i][j] = !(ge[i] | (eq[i] & (j < i)));
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stamp_cnt_r <= '0;
      for (int i = 0; i < JOBS; i++) begin
        srem_r[i]   <= '0;
        ssts_r[i]   <= '0;
        sstamp_r[i] <= '0;
        for (int j = 0; j < JOBS; j++) begin
          newer_r[i][j] <= (i < j);
        end
      end
    end else begin
      if (add_en) begin
        stamp_cnt_r <= stamp_nxt;
      end
      for (int i = 0; i < JOBS; i++) begin
        newer_r[i] <= newer_nxt[i];
        if (add_en && add_hit[i]) begin
          srem_r[i]   <= cnt_r;
          ssts_r[i]   <= jst_r;
          sstamp_r[i] <= stamp_nxt;
        end else if (done_en && done_hit[i]) begin
          srem_r[i] <= srem_r[i] - CNT_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < JOBS; i++) begin
      if (add_en && add_hit[i]) begin
        sgrp_r[i] <= grp_r;
      end
    end
  end

  // per-item result fields, captured at execute
  logic [SW-1:0]    res_idx_r, res_idx_nxt;
  logic             res_ok_r, res_ok_nxt;
  logic [CNT_W-1:0] res_rem_r, res_rem_nxt;
  logic [JST_W-1:0] res_st_r, res_st_nxt;
  logic [SW-1:0]    rd_sel;

  assign rd_sel = SW'(rslot_r);

  always_comb begin
    res_idx_nxt = '0;
    res_ok_nxt  = 1'b0;
    res_rem_nxt = '0;
    res_st_nxt  = '0;
    case (act_r)
      ACT_BIND: begin
        res_ok_nxt = pid_ok;
      end
      ACT_ADD: begin
        if (add_en && add_any) begin
          res_idx_nxt = enc(add_hit);
          res_ok_nxt  = 1'b1;
        end
      end
      ACT_DONE: begin
        if (done_en && done_last) begin
          res_idx_nxt = enc(done_hit);
          res_ok_nxt  = 1'b1;
        end
      end
      ACT_READ: begin
        if (32'(rslot_r) < JOBS_U) begin
          res_ok_nxt  = 1'b1;
          res_rem_nxt = srem_r[rd_sel];
          res_st_nxt  = ssts_r[rd_sel];
        end
      end
      default: begin
        res_ok_nxt = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      res_idx_r <= res_idx_nxt;
      res_ok_r  <= res_ok_nxt;
      res_rem_r <= res_rem_nxt;
      res_st_r  <= res_st_nxt;
    end
  end

  // newest and second-newest active slots from the age matrix
  always_comb begin
    for (int i = 0; i < JOBS; i++) begin
      is_cur[i] = active[i];
      for (int j = 0; j < JOBS; j++) begin
        if ((j != i) && active[j] && !newer_r[i][j]) begin
          is_cur[i] = 1'b0;
        end
      end
    end
    for (int i = 0; i < JOBS; i++) begin
      is_prev[i] = active[i] && !is_cur[i];
      for (int j = 0; j < JOBS; j++) begin
        if ((j != i) && active[j] && !is_cur[j] && !newer_r[i][j]) begin
          is_prev[i] = 1'b0;
        end
      end
    end
  end

  logic [OUT_TDATA_W-1:0] out_word;
  logic [OUT_TDATA_W-1:0] out_tdata_r;

  always_comb begin
    out_word = '0;
    out_word[OIDX_LO +: SLOT_W]  = SLOT_W'(res_idx_r);
    out_word[OOK_LO]             = res_ok_r;
    out_word[OREM_LO +: CNT_W]   = res_rem_r;
    out_word[OST_LO +: JST_W]    = res_st_r;
    out_word[OCUR_LO +: SLOT_W]  = SLOT_W'(enc(is_cur));
    out_word[OPREV_LO +: SLOT_W] = SLOT_W'(enc(is_prev));
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_tdata_r <= out_word;
    end
  end

  assign out_tdata = out_tdata_r;

  a_one_free: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(add_hit) && $onehot0(done_hit))
    else $error("slot search picked more than one slot");

  a_cur_unique: assert property (@(posedge clk) disable iff (!rst_n)
    (|active) |-> $onehot(is_cur))
    else $error("age matrix gives no single newest slot");

  a_prev_unique: assert property (@(posedge clk) disable iff (!rst_n)
    ($countones(active) > 1) |-> ($onehot(is_prev) && ((is_cur & is_prev) == '0)))
    else $error("age matrix gives no single second-newest slot");

endmodule

// ----- sv/job_slot_table_with_age_order.sv -----
// Job slot table with age order, top level. Depends on jst_pkg, jst_ctrl, jst_dp.
// A transfer latches the item and starts the map RAM read; the execute step
// then updates the slot table, and the finish step loads the output register.
// The next item can be taken during the finish step; a held output stalls it.
// Reset: synchronous, active low; a clearing pass over all PROCS map entries
// (1024 by default) zeroes the process map while in_tready stays low.
module job_slot_table_with_age_order #(
  parameter int JOBS  = jst_pkg::JOBS_DEF,
  parameter int PROCS = jst_pkg::PROCS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // input channel
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // process_id[9:0], group_id[31:10], proc_count[39:32], job_state[42:40],
  // slot[46:43], zero pad [47]
  input  logic [jst_pkg::IN_TDATA_W-1:0]  in_tdata,
  // action[1:0]
  input  logic [jst_pkg::IN_TUSER_W-1:0]  in_tuser,
  // result channel
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // slot_index[3:0], ok[4], remaining[12:5], slot_state[15:13],
  // latest_job[19:16], prior_job[23:20]
  output logic [jst_pkg::OUT_TDATA_W-1:0] out_tdata
);
  import jst_pkg::*;

  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  // Controller: sequence clear, latch, execute and finish; own the result
  // valid so a finished result waits in the output register while the next
  // transfer is taken.
  jst_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .stat       (stat),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd)
  );

  // Datapath: latch the item and read the map on transfer, update the slot
  // table and age matrix on execute, then pack the result together with the
  // newest and second-newest active slots.
  jst_dp #(
    .JOBS  (JOBS),
    .PROCS (PROCS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .stat      (stat),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tdata (out_tdata)
  );

endmodule
